// ===== rtl/bpr_pkg.sv =====
`default_nettype none

package bpr_pkg;

   // Field widths of the request, response and register port
   localparam int OP_W        = 3;
   localparam int INDEX_W     = 12;
   localparam int DATA_W      = 8;
   localparam int SLEN_W      = 13;
   localparam int LEN_W       = 7;
   localparam int COUNT_W     = 13;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;

   // Request kinds carried on req_tuser
   localparam logic [OP_W-1:0] OP_LOAD_PAT  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_REP  = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE_SEC = 3'd2;
   localparam logic [OP_W-1:0] OP_RUN       = 3'd3;
   localparam logic [OP_W-1:0] OP_READ      = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SECTOR_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_LEN = 2'd2;

   localparam logic [SLEN_W-1:0] SECTOR_LEN_RESET  = 13'd2352;
   localparam logic [LEN_W-1:0]  PATTERN_LEN_RESET = 7'd1;
   localparam logic [LEN_W-1:0]  REPLACE_LEN_RESET = 7'd0;

   typedef struct packed {
      logic wr_pat;      // store req data into the pattern buffer
      logic wr_rep;      // store req data into the replacement buffer
      logic wr_sec;      // store req data into the sector buffer
      logic rd_sec;      // read sector at req index
      logic run_init;    // latch lengths, clear start, offset and count
      logic cmp_issue;   // read sector at start + offset and pattern at offset
      logic cmp_next;    // advance compare offset
      logic hit;         // count the match and rewind offset
      logic rep_write;   // write replacement byte, advance offset
      logic start_next;  // advance start, rewind offset
      logic rsp_read;    // load response with read byte
      logic rsp_count;   // load response with match count
   } dp_cmd_type;

   typedef struct packed {
      logic scan_more;   // start + pattern length fits in sector
      logic cmp_more;    // offset below pattern length
      logic bytes_equal; // fetched sector byte equals pattern byte
      logic rep_more;    // offset below replace length and inside sector
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/bpr_datapath.sv =====
`default_nettype none

module bpr_datapath #(
   parameter int MAX_SECTOR  = 4096,
   parameter int MAX_PATTERN = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [bpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bpr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [bpr_pkg::INDEX_W-1:0]      req_index,
   input  wire logic [bpr_pkg::DATA_W-1:0]       req_data,
   input  wire bpr_pkg::dp_cmd_type              cmd,
   output bpr_pkg::dp_status_type                status,
   output logic                                  rsp_is_count,
   output logic [bpr_pkg::DATA_W-1:0]            rsp_read_byte,
   output logic [bpr_pkg::COUNT_W-1:0]           rsp_match_count
);
   import bpr_pkg::*;

   localparam int SA   = $clog2(MAX_SECTOR);
   localparam int PA   = $clog2(MAX_PATTERN);
   localparam int LW   = $clog2(MAX_PATTERN + 1);
   localparam int PW_A = $clog2(MAX_SECTOR + MAX_PATTERN + 1);
   localparam int PW   = ((PW_A > SLEN_W) ? PW_A : SLEN_W) + 1;

   // Configuration registers
   logic [SLEN_W-1:0] sector_len_ff;
   logic [LEN_W-1:0]  pattern_len_ff;
   logic [LEN_W-1:0]  replace_len_ff;

   // Scan control
   logic [PW-1:0]      start_ff, start_in;
   logic [LW-1:0]      offs_ff, offs_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PW-1:0]      slen_ff, slen_in;
   logic [LW-1:0]      plen_ff, plen_in;
   logic [LW-1:0]      rlen_ff, rlen_in;
   logic               rd_oob_ff;

   // Storage
   logic [DATA_W-1:0] sector_mem [MAX_SECTOR];
   logic [DATA_W-1:0] pat_mem    [MAX_PATTERN];
   logic [DATA_W-1:0] rep_mem    [MAX_PATTERN];
   logic [DATA_W-1:0] sec_rdata_ff;
   logic [DATA_W-1:0] pat_rdata_ff;
   logic [DATA_W-1:0] rep_rdata_ff;

   logic              rsp_is_count_ff;
   logic [DATA_W-1:0] rsp_byte_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [PW-1:0]     idx_ext;
   logic [PW-1:0]     pos;
   logic              sec_idx_ok;
   logic              pat_idx_ok;
   logic              sec_we;
   logic [SA-1:0]     sec_waddr;
   logic [SA-1:0]     sec_raddr;
   logic [DATA_W-1:0] sec_wdata;

   assign idx_ext    = PW'(req_index);
   assign pos        = start_ff + PW'(offs_ff);
   assign sec_idx_ok = idx_ext < PW'(MAX_SECTOR);
   assign pat_idx_ok = idx_ext < PW'(MAX_PATTERN);

   assign sec_we    = (cmd.wr_sec && sec_idx_ok) || cmd.rep_write;
   assign sec_waddr = cmd.rep_write ? pos[SA-1:0] : idx_ext[SA-1:0];
   assign sec_wdata = cmd.rep_write ? rep_rdata_ff : req_data;
   assign sec_raddr = cmd.rd_sec ? idx_ext[SA-1:0] : pos[SA-1:0];

   always_ff @(posedge clock) begin
      if (sec_we) begin
         sector_mem[sec_waddr] <= sec_wdata;
      end
      sec_rdata_ff <= sector_mem[sec_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_pat && pat_idx_ok) begin
         pat_mem[req_index[PA-1:0]] <= req_data;
      end
      if (cmd.cmp_issue) begin
         pat_rdata_ff <= pat_mem[offs_ff[PA-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_rep && pat_idx_ok) begin
         rep_mem[req_index[PA-1:0]] <= req_data;
      end
      rep_rdata_ff <= rep_mem[offs_ff[PA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_len_ff  <= SECTOR_LEN_RESET;
         pattern_len_ff <= PATTERN_LEN_RESET;
         replace_len_ff <= REPLACE_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_SECTOR_LEN:  sector_len_ff  <= csr_wdata;
            REG_PATTERN_LEN: pattern_len_ff <= csr_wdata[LEN_W-1:0];
            REG_REPLACE_LEN: replace_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate lengths to the buffer sizes once per run
   always_comb begin
      slen_in = (PW'(sector_len_ff) > PW'(MAX_SECTOR)) ? PW'(MAX_SECTOR)
                                                       : PW'(sector_len_ff);
      plen_in = (PW'(pattern_len_ff) > PW'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                         : LW'(pattern_len_ff);
      rlen_in = (PW'(replace_len_ff) > PW'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                         : LW'(replace_len_ff);
   end

   always_comb begin
      start_in = start_ff;
      offs_in  = offs_ff;
      count_in = count_ff;
      if (cmd.run_init) begin
         start_in = '0;
         offs_in  = '0;
         count_in = '0;
      end else if (cmd.start_next) begin
         start_in = start_ff + PW'(1);
         offs_in  = '0;
      end else if (cmd.hit) begin
         offs_in  = '0;
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.cmp_next || cmd.rep_write) begin
         offs_in  = offs_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      offs_ff  <= offs_in;
      count_ff <= count_in;
      if (cmd.run_init) begin
         slen_ff <= slen_in;
         plen_ff <= plen_in;
         rlen_ff <= rlen_in;
      end
      if (cmd.rd_sec) begin
         rd_oob_ff <= !sec_idx_ok;
      end
      if (cmd.rsp_read) begin
         rsp_is_count_ff <= 1'b0;
         rsp_byte_ff     <= rd_oob_ff ? '0 : sec_rdata_ff;
         rsp_count_ff    <= '0;
      end else if (cmd.rsp_count) begin
         rsp_is_count_ff <= 1'b1;
         rsp_byte_ff     <= '0;
         rsp_count_ff    <= count_ff;
      end
   end

   always_comb begin
      status.scan_more   = (start_ff + PW'(plen_ff)) <= slen_ff;
      status.cmp_more    = offs_ff < plen_ff;
      status.bytes_equal = sec_rdata_ff == pat_rdata_ff;
      status.rep_more    = (offs_ff < rlen_ff) && (pos < slen_ff);
   end

   assign rsp_is_count    = rsp_is_count_ff;
   assign rsp_read_byte   = rsp_byte_ff;
   assign rsp_match_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/bpr_ctrl.sv =====
`default_nettype none

module bpr_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [bpr_pkg::OP_W-1:0]    req_op,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire bpr_pkg::dp_status_type      status,
   output bpr_pkg::dp_cmd_type              cmd
);
   import bpr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_SCAN,
      ST_CMP,
      ST_CHK,
      ST_REP,
      ST_REP_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_LOAD_PAT:  cmd.wr_pat = 1'b1;
                  OP_LOAD_REP:  cmd.wr_rep = 1'b1;
                  OP_WRITE_SEC: cmd.wr_sec = 1'b1;
                  OP_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = ST_SCAN;
                  end
                  OP_READ: begin
                     cmd.rd_sec = 1'b1;
                     state_in   = ST_RD_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_WAIT: begin
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            state_in = status.scan_more ? ST_CMP : ST_DONE;
         end
         ST_CMP: begin
            if (status.cmp_more) begin
               cmd.cmp_issue = 1'b1;
               state_in      = ST_CHK;
            end else begin
               // whole pattern matched
               cmd.hit  = 1'b1;
               state_in = ST_REP;
            end
         end
         ST_CHK: begin
            if (status.bytes_equal) begin
               cmd.cmp_next = 1'b1;
               state_in     = ST_CMP;
            end else begin
               cmd.start_next = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_REP: begin
            if (status.rep_more) begin
               // replacement byte is fetched at the current offset
               state_in = ST_REP_WR;
            end else begin
               cmd.start_next = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_REP_WR: begin
            cmd.rep_write = 1'b1;
            state_in      = ST_REP;
         end
         ST_DONE: begin
            cmd.rsp_count = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_read || cmd.rsp_count) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/byte_pattern_replace_all.sv =====
`default_nettype none

// Byte pattern search and replace over a sector buffer. Load beats write one
// byte of the pattern, replacement or sector buffer; a read beat returns its
// sector byte as a response, registered in the sector read register and then
// in the response register. A run beat scans every start position in
// ascending order, compares the buffer (including earlier replacements) with
// the pattern and rewrites each match, then returns the match count. The scan
// is one sequencer sharing the buffers: a scan state per start, a compare and
// a check state per compared byte, and per match a hit plus a fetch and a
// write state per replacement byte. No new beat is taken during a run. Buffer
// contents are undefined until written. Only one response is held; a new beat
// is taken while it waits only if it is being drained in the same cycle.
module byte_pattern_replace_all #(
   parameter int MAX_SECTOR  = 4096,
   parameter int MAX_PATTERN = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [bpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bpr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bpr_pkg::REQ_TDATA_W-1:0]   req_tdata,  // index, data, zero pad
   input  wire logic [bpr_pkg::OP_W-1:0]          req_tuser,  // op
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bpr_pkg::RSP_TDATA_W-1:0]        rsp_tdata,  // read_byte, match_count, pad
   output logic                                   rsp_tuser   // is_count
);
   import bpr_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [DATA_W-1:0]   rsp_read_byte;
   logic [COUNT_W-1:0]  rsp_match_count;

   bpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bpr_datapath #(
      .MAX_SECTOR  (MAX_SECTOR),
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_index       (req_tdata[INDEX_W-1:0]),
      .req_data        (req_tdata[INDEX_W +: DATA_W]),
      .cmd             (cmd),
      .status          (status),
      .rsp_is_count    (rsp_tuser),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_match_count (rsp_match_count)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - DATA_W - COUNT_W){1'b0}},
                       rsp_match_count, rsp_read_byte};

   // A beat is taken only when the response slot is free or draining
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("request taken while response slot is occupied");

   // A read beat raises response valid through the read and response registers
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_READ) |=> ##1 rsp_tvalid)
      else $error("read response missing");

   // Count and byte fields never both carry data
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser ? (rsp_tdata[DATA_W-1:0] == '0)
                                : (rsp_tdata[DATA_W +: COUNT_W] == '0)))
      else $error("response carries stray field");

endmodule

`default_nettype wire
